>>> rtl/salc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types and constants of the set-associative LRU cache tag store.
// ----------------------------------------------------------------------------
package salc_pkg;

    localparam int SET_BITS   = 6;
    localparam int NUM_SETS   = 1 << SET_BITS;
    localparam int WAYS       = 8;
    localparam int WAY_W      = 3;
    localparam int ADDR_W     = 64;
    localparam int CNT_W      = 32;
    localparam int S_W        = 3;
    localparam int B_W        = 6;
    localparam int E_W        = 4;
    localparam int MAX_OFFSET = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SET_BITS    = 2'd0,
        CFG_OFFSET_BITS = 2'd1,
        CFG_WAYS        = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [S_W-1:0] s;
        logic [B_W-1:0] b;
        logic [E_W-1:0] e;
    } geom_t;

    typedef struct packed {
        logic [SET_BITS-1:0] set;
        logic [ADDR_W-1:0]   tag;
        logic                write;
    } req_t;

    typedef struct packed {
        logic [WAYS-1:0]             valid;
        logic [WAYS-1:0]             dirty;
        logic [WAYS-1:0][ADDR_W-1:0] tag;
        logic [WAYS-1:0][WAYS-1:0]   older;
    } row_t;

endpackage

>>> rtl/salc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_front
// Accepts requests and splits the address into set index and tag.
// ----------------------------------------------------------------------------
module salc_front (
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [salc_pkg::ADDR_W-1:0]   s_addr,
    input  logic                          s_action,
    input  salc_pkg::geom_t               geom,
    input  logic                          q_full,
    output logic                          q_push,
    output salc_pkg::req_t                q_req
);

    logic [salc_pkg::ADDR_W-1:0]   shifted;
    logic [salc_pkg::SET_BITS:0]   set_mask;
    logic [salc_pkg::B_W:0]        tag_shift;

    always_comb begin
        shifted   = s_addr >> geom.b;
        set_mask  = (7'(1) << geom.s) - 7'd1;
        tag_shift = 7'(geom.b) + 7'(geom.s);
        q_req.set   = shifted[salc_pkg::SET_BITS-1:0] & set_mask[salc_pkg::SET_BITS-1:0];
        q_req.tag   = s_addr >> tag_shift;
        q_req.write = s_action;
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

endmodule

>>> rtl/salc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_queue
// Two-entry request queue between front and back.
// ----------------------------------------------------------------------------
module salc_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  salc_pkg::req_t push_req,
    input  logic           pop,
    output salc_pkg::req_t pop_req,
    output logic           full,
    output logic           empty
);

    salc_pkg::req_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_req;
        end
    end

    assign pop_req = entry_reg[rd_ptr_reg];
    assign full    = count_reg == 2'd2;
    assign empty   = count_reg == 2'd0;

endmodule

>>> rtl/salc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_back
// Set read, tag compare, LRU update, write-back of the set row, result register.
// ----------------------------------------------------------------------------
module salc_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  salc_pkg::geom_t               geom,
    input  logic                          q_empty,
    input  salc_pkg::req_t                q_req,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_hit,
    output logic                          m_victim_valid,
    output logic                          m_victim_dirty,
    output logic [salc_pkg::ADDR_W-1:0]   m_victim_addr,
    output logic [salc_pkg::CNT_W-1:0]    m_hits_total,
    output logic [salc_pkg::CNT_W-1:0]    m_misses_total,
    output logic [salc_pkg::CNT_W-1:0]    m_dirty_evictions_total,
    output logic [salc_pkg::CNT_W-1:0]    m_clean_evictions_total
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LOOK = 2'b10
    } state_t;

    localparam int W = salc_pkg::WAYS;

    state_t state_reg, state_next;

    salc_pkg::row_t              mem [salc_pkg::NUM_SETS];
    logic [salc_pkg::NUM_SETS-1:0] row_valid_reg;
    salc_pkg::row_t              rd_row_reg;
    logic                        rd_row_valid_reg;
    salc_pkg::req_t              req_reg;

    logic                        m_valid_reg;
    logic                        hit_reg, vvalid_reg, vdirty_reg;
    logic [salc_pkg::ADDR_W-1:0] vaddr_reg, vaddr_next;
    logic [salc_pkg::CNT_W-1:0]  hits_reg, hits_next, miss_reg, miss_next;
    logic [salc_pkg::CNT_W-1:0]  dev_reg, dev_next, cev_reg, cev_next;

    salc_pkg::row_t   cur, upd;
    logic [W-1:0]     emask, hitv, invv, lruv;
    logic             hit, have_inv, vvalid, vdirty;
    logic [salc_pkg::WAY_W-1:0] hway, iway, lway, pick;
    logic             out_free, do_read, do_exec;

    always_comb begin
        cur = rd_row_valid_reg ? rd_row_reg : '0;
        for (int w = 0; w < W; w++) begin
            emask[w] = 4'(w) < geom.e;
            hitv[w]  = emask[w] && cur.valid[w] && (cur.tag[w] == req_reg.tag);
            invv[w]  = emask[w] && !cur.valid[w];
            lruv[w]  = emask[w];
            for (int j = 0; j < W; j++) begin
                if (j != w && emask[j] && !cur.older[w][j]) begin
                    lruv[w] = 1'b0;
                end
            end
        end
        hway = '0;
        iway = '0;
        lway = '0;
        for (int w = W - 1; w >= 0; w--) begin
            if (hitv[w]) hway = salc_pkg::WAY_W'(w);
            if (invv[w]) iway = salc_pkg::WAY_W'(w);
            if (lruv[w]) lway = salc_pkg::WAY_W'(w);
        end
        hit      = |hitv;
        have_inv = |invv;
        pick     = hit ? hway : (have_inv ? iway : lway);
        vvalid   = !hit && cur.valid[pick];
        vdirty   = !hit && cur.dirty[pick];
        vaddr_next = hit ? '0 :
            ((cur.tag[pick] << (7'(geom.s) + 7'(geom.b)))
             | (salc_pkg::ADDR_W'(req_reg.set) << geom.b));

        upd = cur;
        for (int j = 0; j < W; j++) begin
            upd.older[pick][j] = 1'b0;
            if (salc_pkg::WAY_W'(j) != pick) begin
                upd.older[j][pick] = 1'b1;
            end
        end
        upd.valid[pick] = 1'b1;
        upd.dirty[pick] = hit ? (cur.dirty[pick] | req_reg.write) : req_reg.write;
        if (!hit) begin
            upd.tag[pick] = req_reg.tag;
        end

        hits_next = (hit && hits_reg != '1) ? hits_reg + 1'b1 : hits_reg;
        miss_next = (!hit && miss_reg != '1) ? miss_reg + 1'b1 : miss_reg;
        dev_next  = (vvalid && vdirty && dev_reg != '1) ? dev_reg + 1'b1 : dev_reg;
        cev_next  = (vvalid && !vdirty && cev_reg != '1) ? cev_reg + 1'b1 : cev_reg;
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        do_read    = 1'b0;
        do_exec    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    do_read    = 1'b1;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (out_free) begin
                    do_exec    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign q_pop = do_read;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            row_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
            hits_reg      <= '0;
            miss_reg      <= '0;
            dev_reg       <= '0;
            cev_reg       <= '0;
        end else begin
            state_reg <= state_next;
            if (do_exec) begin
                row_valid_reg[req_reg.set] <= 1'b1;
                hits_reg <= hits_next;
                miss_reg <= miss_next;
                dev_reg  <= dev_next;
                cev_reg  <= cev_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_read) begin
            rd_row_reg       <= mem[q_req.set];
            rd_row_valid_reg <= row_valid_reg[q_req.set];
            req_reg          <= q_req;
        end
        if (do_exec) begin
            mem[req_reg.set] <= upd;
            hit_reg    <= hit;
            vvalid_reg <= vvalid;
            vdirty_reg <= vdirty;
            vaddr_reg  <= vaddr_next;
        end
    end

    assign m_valid                 = m_valid_reg;
    assign m_hit                   = hit_reg;
    assign m_victim_valid          = vvalid_reg;
    assign m_victim_dirty          = vdirty_reg;
    assign m_victim_addr           = vaddr_reg;
    assign m_hits_total            = hits_reg;
    assign m_misses_total          = miss_reg;
    assign m_dirty_evictions_total = dev_reg;
    assign m_clean_evictions_total = cev_reg;

endmodule

>>> rtl/set_assoc_lru_cache_tags_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags_top
// A request passes the queue, the set row read register and the result register.
// One request at a time in the back: the next set row is read only after the last update.
// Reset: synchronous active low; all sets read as invalid, counters cleared,
// configuration back to 4 set bits, 6 offset bits, 8 ways. No clearing pass.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tags_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [salc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [salc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [salc_pkg::ADDR_W-1:0]       s_addr,
    input  logic                              s_action,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_hit,
    output logic                              m_victim_valid,
    output logic                              m_victim_dirty,
    output logic [salc_pkg::ADDR_W-1:0]       m_victim_addr,
    output logic [salc_pkg::CNT_W-1:0]        m_hits_total,
    output logic [salc_pkg::CNT_W-1:0]        m_misses_total,
    output logic [salc_pkg::CNT_W-1:0]        m_dirty_evictions_total,
    output logic [salc_pkg::CNT_W-1:0]        m_clean_evictions_total
);

    logic [salc_pkg::S_W-1:0] set_bits_reg;
    logic [salc_pkg::B_W-1:0] offset_bits_reg;
    logic [salc_pkg::E_W-1:0] ways_reg;
    salc_pkg::geom_t          geom;
    salc_pkg::req_t           push_req, pop_req;
    logic                     q_push, q_pop, q_full, q_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_bits_reg    <= 3'd4;
            offset_bits_reg <= 6'd6;
            ways_reg        <= 4'd8;
        end else if (cfg_valid) begin
            case (cfg_index)
                salc_pkg::CFG_SET_BITS:    set_bits_reg    <= cfg_data[salc_pkg::S_W-1:0];
                salc_pkg::CFG_OFFSET_BITS: offset_bits_reg <= cfg_data;
                salc_pkg::CFG_WAYS:        ways_reg        <= cfg_data[salc_pkg::E_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        geom.s = (set_bits_reg > salc_pkg::S_W'(salc_pkg::SET_BITS))
               ? salc_pkg::S_W'(salc_pkg::SET_BITS) : set_bits_reg;
        geom.b = (offset_bits_reg > salc_pkg::B_W'(salc_pkg::MAX_OFFSET))
               ? salc_pkg::B_W'(salc_pkg::MAX_OFFSET) : offset_bits_reg;
        if (ways_reg == '0) begin
            geom.e = salc_pkg::E_W'(1);
        end else if (ways_reg > salc_pkg::E_W'(salc_pkg::WAYS)) begin
            geom.e = salc_pkg::E_W'(salc_pkg::WAYS);
        end else begin
            geom.e = ways_reg;
        end
    end

    salc_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_addr  (s_addr),
        .s_action(s_action),
        .geom    (geom),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_req   (push_req)
    );

    salc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_req(push_req),
        .pop     (q_pop),
        .pop_req (pop_req),
        .full    (q_full),
        .empty   (q_empty)
    );

    salc_back u_back (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .geom                   (geom),
        .q_empty                (q_empty),
        .q_req                  (pop_req),
        .q_pop                  (q_pop),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_hit                  (m_hit),
        .m_victim_valid         (m_victim_valid),
        .m_victim_dirty         (m_victim_dirty),
        .m_victim_addr          (m_victim_addr),
        .m_hits_total           (m_hits_total),
        .m_misses_total         (m_misses_total),
        .m_dirty_evictions_total(m_dirty_evictions_total),
        .m_clean_evictions_total(m_clean_evictions_total)
    );

endmodule

>>> rtl/salc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salc_checker
// Port-level checks of the cache tag store results.
// ----------------------------------------------------------------------------
module salc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic                            m_hit,
    input logic                            m_victim_valid,
    input logic                            m_victim_dirty,
    input logic [salc_pkg::ADDR_W-1:0]     m_victim_addr,
    input logic [salc_pkg::CNT_W-1:0]      m_misses_total,
    input logic [salc_pkg::CNT_W-1:0]      m_dirty_evictions_total,
    input logic [salc_pkg::CNT_W-1:0]      m_clean_evictions_total
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_hit_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> !m_victim_valid && !m_victim_dirty && m_victim_addr == '0)
        else $error("hit carries victim info");

    a_miss_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_misses_total != '0)
        else $error("miss not counted");

    a_evict_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_victim_valid |->
            m_dirty_evictions_total != '0 || m_clean_evictions_total != '0)
        else $error("eviction not counted");

endmodule

bind set_assoc_lru_cache_tags_top salc_checker u_salc_checker (
    .aclk                   (aclk),
    .aresetn                (aresetn),
    .m_valid                (m_valid),
    .m_ready                (m_ready),
    .m_hit                  (m_hit),
    .m_victim_valid         (m_victim_valid),
    .m_victim_dirty         (m_victim_dirty),
    .m_victim_addr          (m_victim_addr),
    .m_misses_total         (m_misses_total),
    .m_dirty_evictions_total(m_dirty_evictions_total),
    .m_clean_evictions_total(m_clean_evictions_total)
);

>>> tb/set_assoc_lru_cache_tags_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags_top_tb
// Drives read/write requests through the LRU cache tag store under several
// geometries. Each accepted request is run through a local model of the tag
// store and its expected result is queued. Results are compared field by field
// in arrival order while both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tags_top_tb;
    import salc_pkg::*;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic              act;
    } access_t;

    typedef struct {
        logic              hit;
        logic              vvalid;
        logic              vdirty;
        logic [ADDR_W-1:0] vaddr;
        logic [CNT_W-1:0]  hits;
        logic [CNT_W-1:0]  misses;
        logic [CNT_W-1:0]  dirty_ev;
        logic [CNT_W-1:0]  clean_ev;
    } lookup_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [ADDR_W-1:0]     s_addr = '0;
    logic                  s_action = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_hit;
    logic                  m_victim_valid;
    logic                  m_victim_dirty;
    logic [ADDR_W-1:0]     m_victim_addr;
    logic [CNT_W-1:0]      m_hits_total;
    logic [CNT_W-1:0]      m_misses_total;
    logic [CNT_W-1:0]      m_dirty_evictions_total;
    logic [CNT_W-1:0]      m_clean_evictions_total;

    set_assoc_lru_cache_tags_top DUT (.*);

    // model of the tag store
    logic              line_v [NUM_SETS*WAYS];
    logic              line_d [NUM_SETS*WAYS];
    logic [ADDR_W-1:0] line_t [NUM_SETS*WAYS];
    logic [63:0]       line_age [NUM_SETS*WAYS];
    logic [63:0]       stamp;
    logic [CNT_W-1:0]  n_hit, n_miss, n_dev, n_cev;
    logic [S_W-1:0]    geo_s;
    logic [B_W-1:0]    geo_b;
    logic [E_W-1:0]    geo_e;

    access_t pending_q[$];
    lookup_t lookup_q[$];
    access_t cur;
    lookup_t got;
    int      errors = 0;
    int      n_sent = 0;
    int      n_checked = 0;
    int      gap = 0;
    int      stall = 0;
    int      hold_cnt = 0;
    bit      hold_req = 0;
    bit      hold_done = 0;
    bit      no_idle = 0;

    function automatic int eff_s();
        return (geo_s > SET_BITS) ? SET_BITS : int'(geo_s);
    endfunction

    function automatic int eff_b();
        return (geo_b > MAX_OFFSET) ? MAX_OFFSET : int'(geo_b);
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic lookup_t lookup(logic [ADDR_W-1:0] addr, logic wr);
        lookup_t r;
        int s, b, e, base, pick;
        logic [ADDR_W-1:0] setv, tagv;
        bit found, inv;
        s = eff_s();
        b = eff_b();
        e = (geo_e == 0) ? 1 : ((geo_e > WAYS) ? WAYS : int'(geo_e));
        setv = (addr >> b) & ((64'd1 << s) - 1);
        tagv = addr >> (b + s);
        base = int'(setv) * WAYS;
        r = '{default: '0};
        found = 0;
        pick = 0;
        for (int w = 0; w < e; w++) begin
            if (!found && line_v[base+w] && line_t[base+w] == tagv) begin
                found = 1;
                pick = w;
            end
        end
        if (found) begin
            n_hit = sat_inc(n_hit);
            line_age[base+pick] = stamp;
            if (wr) line_d[base+pick] = 1'b1;
        end else begin
            n_miss = sat_inc(n_miss);
            inv = 0;
            for (int w = 0; w < e; w++) begin
                if (!inv && !line_v[base+w]) begin
                    inv = 1;
                    pick = w;
                end
            end
            if (!inv) begin
                pick = 0;
                for (int w = 1; w < e; w++)
                    if (line_age[base+w] < line_age[base+pick]) pick = w;
            end
            r.vvalid = line_v[base+pick];
            r.vdirty = line_d[base+pick];
            r.vaddr  = (line_t[base+pick] << (s + b)) | (setv << b);
            if (r.vvalid) begin
                if (r.vdirty) n_dev = sat_inc(n_dev);
                else n_cev = sat_inc(n_cev);
            end
            line_v[base+pick]   = 1'b1;
            line_t[base+pick]   = tagv;
            line_d[base+pick]   = wr;
            line_age[base+pick] = stamp;
        end
        stamp++;
        r.hit      = found;
        r.hits     = n_hit;
        r.misses   = n_miss;
        r.dirty_ev = n_dev;
        r.clean_ev = n_cev;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2ms;
        $display("DONE: errors detected");
        $finish;
    end

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                lookup_q.push_back(lookup(s_addr, s_action));
                n_sent++;
            end
            if (!s_valid || s_ready) begin
                if (gap > 0) begin
                    gap <= gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    cur = pending_q.pop_front();
                    s_valid  <= 1'b1;
                    s_addr   <= cur.addr;
                    s_action <= cur.act;
                    gap <= pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (lookup_q.size() == 0) begin
                    $error("result with no request outstanding");
                    errors++;
                end else begin
                    got = lookup_q.pop_front();
                    n_checked++;
                    if (m_hit !== got.hit) begin
                        $error("hit exp %0h got %0h", got.hit, m_hit);
                        errors++;
                    end
                    if (m_victim_valid !== got.vvalid) begin
                        $error("victim_valid exp %0h got %0h", got.vvalid, m_victim_valid);
                        errors++;
                    end
                    if (m_victim_dirty !== got.vdirty) begin
                        $error("victim_dirty exp %0h got %0h", got.vdirty, m_victim_dirty);
                        errors++;
                    end
                    if (m_victim_addr !== got.vaddr) begin
                        $error("victim_addr exp %0h got %0h", got.vaddr, m_victim_addr);
                        errors++;
                    end
                    if (m_hits_total !== got.hits) begin
                        $error("hits_total exp %0d got %0d", got.hits, m_hits_total);
                        errors++;
                    end
                    if (m_misses_total !== got.misses) begin
                        $error("misses_total exp %0d got %0d", got.misses, m_misses_total);
                        errors++;
                    end
                    if (m_dirty_evictions_total !== got.dirty_ev) begin
                        $error("dirty_evictions_total exp %0d got %0d",
                               got.dirty_ev, m_dirty_evictions_total);
                        errors++;
                    end
                    if (m_clean_evictions_total !== got.clean_ev) begin
                        $error("clean_evictions_total exp %0d got %0d",
                               got.clean_ev, m_clean_evictions_total);
                        errors++;
                    end
                end
            end
            if (hold_req && !hold_done) begin
                hold_done <= 1;
                hold_cnt <= 300;
                m_ready <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                m_ready <= (hold_cnt == 1);
            end else if (stall > 0) begin
                stall <= stall - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                stall <= pick_gap();
            end
        end
    end

    task automatic send(logic [ADDR_W-1:0] addr, logic act);
        pending_q.push_back('{addr: addr, act: act});
    endtask

    // sampled away from the rising edge so driver updates have settled
    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_q.size() != 0 || s_valid || lookup_q.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic cfg_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SET_BITS:    geo_s = d[S_W-1:0];
            CFG_OFFSET_BITS: geo_b = d[B_W-1:0];
            CFG_WAYS:        geo_e = d[E_W-1:0];
            default: ;
        endcase
    endtask

    task automatic geometry(int s, int b, int e);
        cfg_write(CFG_SET_BITS, CFG_DATA_W'(s));
        cfg_write(CFG_OFFSET_BITS, CFG_DATA_W'(b));
        cfg_write(CFG_WAYS, CFG_DATA_W'(e));
    endtask

    // mostly a small tag pool over a few sets so lines hit, age and evict
    task automatic random_phase(int n);
        logic [ADDR_W-1:0] pool[10];
        logic [ADDR_W-1:0] a, setv;
        int s, b, top;
        s = eff_s();
        b = eff_b();
        top = (1 << s) - 1;
        if (top > 3) top = 3;
        foreach (pool[i]) pool[i] = {$urandom, $urandom};
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 15) begin
                a = {$urandom, $urandom};
            end else begin
                setv = $urandom_range(0, top);
                a = (pool[$urandom_range(0, 9)] << (s + b)) | (setv << b)
                    | ({$urandom, $urandom} & ((64'd1 << b) - 1));
            end
            send(a, $urandom_range(0, 1));
        end
        wait_idle();
    endtask

    initial begin
        foreach (line_v[i]) begin
            line_v[i] = 0;
            line_d[i] = 0;
            line_t[i] = '0;
            line_age[i] = '0;
        end
        stamp = '0;
        {n_hit, n_miss, n_dev, n_cev} = '0;
        geo_s = 4;
        geo_b = 6;
        geo_e = 8;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: fill set 1 past its ways, dirty some lines, evict by LRU
        no_idle = 1;
        for (int t = 0; t < 8; t++) send((64'(t) << 10) | (64'd1 << 6), t[0]);
        send((64'd0 << 10) | (64'd1 << 6) | 64'h3f, 1'b0);
        send((64'd3 << 10) | (64'd1 << 6), 1'b1);
        send((64'd9 << 10) | (64'd1 << 6), 1'b0);
        send((64'd10 << 10) | (64'd1 << 6), 1'b1);
        send((64'd11 << 10) | (64'd1 << 6), 1'b0);
        send(64'd0, 1'b0);
        send('1, 1'b1);
        send('1, 1'b0);
        send(64'h5555_5555_5555_5555, 1'b1);
        send(64'haaaa_aaaa_aaaa_aaaa, 1'b0);
        wait_idle();

        geometry(0, 0, 1);
        send(64'd0, 1'b1);
        send(64'd1, 1'b0);
        send(64'd1, 1'b1);
        send('1, 1'b0);
        wait_idle();

        no_idle = 0;
        random_phase(110);
        geometry(7, 63, 15);
        random_phase(100);
        geometry(6, 32, 8);
        hold_req = 1;
        no_idle = 1;
        random_phase(100);
        no_idle = 0;
        geometry(3, 5, 0);
        random_phase(100);
        geometry(2, 12, 3);
        random_phase(100);
        geometry(4, 6, 8);
        random_phase(110);

        repeat (10) @(posedge aclk);
        $display("Run covered %0d requests over 7 geometries, %0d results checked.",
                 n_sent, n_checked);
        $display("Model totals: %0d hits, %0d misses, %0d dirty and %0d clean evictions.",
                 n_hit, n_miss, n_dev, n_cev);
        if (errors == 0 && lookup_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
